### hdl/mpbs_pkg.sv
// ----------------------------------------------------------------------------
// mpbs_pkg
// Shared types, constants and the per-position signature compare for the
// multi-pattern byte scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mpbs_pkg;

  localparam int SLOT_COUNT  = 6;
  localparam int SLOT_BITS   = 3;
  localparam int OFFSET_BITS = 24;
  localparam int COUNT_BITS  = 24;
  localparam int SLOT_WIDTH  = 26;
  localparam int OUT_TDATA_W = 56;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef logic [SLOT_WIDTH-1:0]       slot_reg_t;
  typedef slot_reg_t [SLOT_COUNT-1:0]  slot_arr_t;

  localparam slot_arr_t SLOT_RESET = {
    26'h289DB00, 26'h28BC000, 26'h34889C0,
    26'h2669000, 26'h38D4000, 26'h2489000
  };

  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic                   kind;
    logic [SLOT_BITS-1:0]   slot;
    logic [OFFSET_BITS-1:0] offset;
    logic [COUNT_BITS-1:0]  total;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;   // number of results pushed this cycle (0..2)
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic                 hit;
    logic [SLOT_BITS-1:0] slot;
    logic [1:0]           len;
  } hit_t;

  // Lowest enabled slot whose signature matches the bytes starting at b0.
  // avail is the number of bytes present from b0 on; longer signatures fail.
  function automatic hit_t match_pos(slot_arr_t slots, logic [7:0] b0,
                                     logic [7:0] b1, logic [7:0] b2,
                                     logic [1:0] avail);
    hit_t       res;
    logic [1:0] len;
    logic       eq;
    res = '0;
    for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
      len = slots[s][25:24];
      eq  = (slots[s][23:16] == b0) && (slots[s][15:8] == b1) &&
            ((len != 2'd3) || (slots[s][7:0] == b2));
      if ((len >= 2'd2) && (len <= avail) && eq) begin
        res.hit  = 1'b1;
        res.slot = SLOT_BITS'(s);
        res.len  = len;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/mpbs_result_queue.sv
// ----------------------------------------------------------------------------
// mpbs_result_queue
// Four-entry result queue; takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module mpbs_result_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire mpbs_pkg::push_t push,
  output logic                space_ok,
  output logic                out_tvalid,
  input  wire                 out_tready,
  output mpbs_pkg::result_t   head
);
  import mpbs_pkg::*;

  result_t    entry_r [QUEUE_DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (count_r != 3'd0);
  assign head       = entry_r[rd_ptr_r];
  // room for a worst-case item (two results) without counting this cycle's pop
  assign space_ok   = (count_r <= 3'd2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.count;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    count_nxt  = count_r + {1'b0, push.count} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entry_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      entry_r[wr_ptr_r + 2'd1] <= push.second;
    end
  end

endmodule

`default_nettype wire

### hdl/multi_pattern_byte_scanner.sv
// ----------------------------------------------------------------------------
// multi_pattern_byte_scanner
// Scans a byte stream for six programmable signatures of two or three bytes,
// reporting non-overlapping matches and a per-section summary.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  in_      | slave     | in_tvalid/in_tready   | tdata byte, tlast end of section
//  out_     | master    | out_tvalid/out_tready | tdata slot/offset/total, tuser kind,
//           |           |                       | tlast final result
//  cfg_     | slave     | cfg_valid/cfg_ready   | cfg_index slot, cfg_data pattern
//
//  One byte per cycle; a byte's results are written into a 4-deep queue at
//  its transaction edge and offered on out_ from the next cycle.
//  Match reports trail the data by up to two bytes.
//  in_tready drops while the queue holds more than two results.
//  Reset (rst_n, synchronous) restores the default signatures and clears
//  the section state. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pattern_byte_scanner (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_tvalid,
  output logic                          in_tready,
  input  wire  [7:0]                    in_tdata,   // [7:0] data_byte
  input  wire                           in_tlast,   // end_of_section
  output logic                          out_tvalid,
  input  wire                           out_tready,
  output logic [mpbs_pkg::OUT_TDATA_W-1:0] out_tdata, // [2:0] slot_hit,
                                                       // [26:3] match_offset,
                                                       // [50:27] match_total
  output logic                          out_tuser,  // result_kind
  output logic                          out_tlast,  // final_result
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [2:0]                    cfg_index,
  input  wire  [mpbs_pkg::SLOT_WIDTH-1:0] cfg_data
);
  import mpbs_pkg::*;

  slot_arr_t              slot_r;
  logic [7:0]             win0_r, win0_nxt;
  logic [7:0]             win1_r, win1_nxt;
  logic [1:0]             fill_r, fill_nxt;
  logic [1:0]             skip_r, skip_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [COUNT_BITS-1:0]  seen_r, seen_nxt;

  logic                   accept;
  logic [7:0]             b0, b1, b2;
  logic [1:0]             cnt;
  logic [OFFSET_BITS-1:0] base;
  logic [COUNT_BITS-1:0]  seen_inc;
  hit_t                   h0, h1, h2;
  hit_t                   win_hit;
  logic [1:0]             win_idx;
  logic                   found;
  logic [1:0]             sk;
  push_t                  push;
  result_t                match_res, summary_res, head;
  logic                   space_ok;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = space_ok;
  assign cfg_ready = 1'b1;

  always_comb begin
    b0 = in_tdata;
    b1 = 8'h00;
    b2 = 8'h00;
    case (fill_r)
      2'd1: begin
        b0 = win0_r;
        b1 = in_tdata;
      end
      2'd2: begin
        b0 = win0_r;
        b1 = win1_r;
        b2 = in_tdata;
      end
      default: ;
    endcase
    cnt      = fill_r + 2'd1;
    base     = pos_r - OFFSET_BITS'(fill_r);
    seen_inc = (seen_r == COUNT_MAX) ? seen_r : seen_r + 1'b1;

    h0 = match_pos(slot_r, b0, b1, b2, cnt);
    h1 = match_pos(slot_r, b1, b2, 8'h00, cnt - 2'd1);
    h2 = match_pos(slot_r, b2, 8'h00, 8'h00, cnt - 2'd2);

    // end of section: walk the pending positions, first match only
    found   = 1'b0;
    win_hit = '0;
    win_idx = 2'd0;
    sk      = skip_r;
    if (sk != 2'd0) begin
      sk = sk - 2'd1;
    end else if (h0.hit) begin
      found   = 1'b1;
      win_hit = h0;
    end
    if (!found && cnt >= 2'd2) begin
      if (sk != 2'd0) begin
        sk = sk - 2'd1;
      end else if (h1.hit) begin
        found   = 1'b1;
        win_hit = h1;
        win_idx = 2'd1;
      end
    end
    if (!found && cnt == 2'd3) begin
      if (sk != 2'd0) begin
        sk = sk - 2'd1;
      end else if (h2.hit) begin
        found   = 1'b1;
        win_hit = h2;
        win_idx = 2'd2;
      end
    end

    match_res.kind   = KIND_MATCH;
    match_res.slot   = win_hit.slot;
    match_res.offset = base + OFFSET_BITS'(win_idx);
    match_res.total  = seen_inc;
    match_res.last   = 1'b0;

    summary_res.kind   = KIND_SUMMARY;
    summary_res.slot   = '0;
    summary_res.offset = '0;
    summary_res.total  = found ? seen_inc : seen_r;
    summary_res.last   = 1'b1;

    win0_nxt = win0_r;
    win1_nxt = win1_r;
    fill_nxt = fill_r;
    skip_nxt = skip_r;
    pos_nxt  = pos_r;
    seen_nxt = seen_r;
    push     = '0;

    if (accept) begin
      if (in_tlast) begin
        win0_nxt = 8'h00;
        win1_nxt = 8'h00;
        fill_nxt = 2'd0;
        skip_nxt = 2'd0;
        pos_nxt  = '0;
        seen_nxt = '0;
        if (found) begin
          push.count  = 2'd2;
          push.first  = match_res;
          push.second = summary_res;
        end else begin
          push.count = 2'd1;
          push.first = summary_res;
        end
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (fill_r == 2'd2) begin
          // full window: decide the oldest position
          win0_nxt = b1;
          win1_nxt = b2;
          if (skip_r != 2'd0) begin
            skip_nxt = skip_r - 2'd1;
          end else if (h0.hit) begin
            skip_nxt         = h0.len - 2'd1;
            seen_nxt         = seen_inc;
            push.count       = 2'd1;
            push.first       = match_res;
            push.first.slot  = h0.slot;
            push.first.offset = base;
          end
        end else begin
          win0_nxt = b0;
          win1_nxt = b1;
          fill_nxt = cnt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= SLOT_RESET;
      fill_r <= '0;
      skip_r <= '0;
      pos_r  <= '0;
      seen_r <= '0;
    end else begin
      if (cfg_valid && (int'(cfg_index) < SLOT_COUNT)) begin
        slot_r[cfg_index] <= cfg_data;
      end
      fill_r <= fill_nxt;
      skip_r <= skip_nxt;
      pos_r  <= pos_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win0_r <= win0_nxt;
    win1_r <= win1_nxt;
  end

  mpbs_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .space_ok   (space_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .head       (head)
  );

  assign out_tdata = {5'b0, head.total, head.offset, head.slot};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for multi_pattern_byte_scanner. A queue-fed driver
// streams bytes and end-of-section marks at random pacing. A clocked monitor
// runs every accepted byte through a local scan model and compares each
// result transaction field by field against the oldest prediction. The
// signature slots are reprogrammed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mpbs_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int BLOCK_BYTES = 57;

  typedef struct {
    logic [7:0] data;
    logic       eos;
  } stream_byte_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [2:0]             cfg_index = '0;
  logic [SLOT_WIDTH-1:0]  cfg_data = '0;

  multi_pattern_byte_scanner DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Scan model state
  slot_reg_t        sig_slots [SLOT_COUNT];
  logic [7:0]       held_bytes [2];
  int               held_count;
  int               skip_count;
  logic [23:0]      next_offset;
  logic [23:0]      section_hits;

  stream_byte_t     byte_queue [$];
  result_t          predicted [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic in_taken = 1'b0;
  int errors = 0;
  int bytes_accepted = 0;
  int reports_seen = 0;
  int summaries_seen = 0;
  int stall_cycles = 0;

  task automatic expect_result(input result_t r);
    predicted.insert(predicted.size(), r);
  endtask

  task automatic queue_byte(input logic [7:0] d, input logic e);
    stream_byte_t sb;
    sb.data = d;
    sb.eos  = e;
    byte_queue.insert(byte_queue.size(), sb);
  endtask

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h5A;
      3: return 8'hA5;
      4: return 8'h48;
      default: return 8'h90;
    endcase
  endfunction

  function automatic slot_reg_t rand_slot();
    logic [1:0] len;
    logic [7:0] b [3];
    int p;
    p = $urandom_range(0, 99);
    len = (p < 8) ? 2'd0 : (p < 16) ? 2'd1 : (p < 58) ? 2'd2 : 2'd3;
    for (int k = 0; k < 3; k++)
      b[k] = ($urandom_range(0, 3) != 0) ? pick_alpha() : 8'($urandom);
    return {len, b[0], b[1], b[2]};
  endfunction

  // Decide one start position; the lowest enabled slot that fits wins.
  function automatic bit judge_position(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input int avail,
                                        input logic [23:0] offset, output result_t r);
    int len;
    r = '0;
    if (skip_count > 0) begin
      skip_count--;
      return 1'b0;
    end
    for (int s = 0; s < SLOT_COUNT; s++) begin
      len = sig_slots[s][25:24];
      if (len < 2 || len > 3 || len > avail) continue;
      if (b0 != sig_slots[s][23:16] || b1 != sig_slots[s][15:8]) continue;
      if (len == 3 && b2 != sig_slots[s][7:0]) continue;
      skip_count = len - 1;
      if (section_hits != COUNT_MAX) section_hits++;
      r.kind   = KIND_MATCH;
      r.slot   = SLOT_BITS'(s);
      r.offset = offset;
      r.total  = section_hits;
      r.last   = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic clear_section();
    held_bytes[0] = '0;
    held_bytes[1] = '0;
    held_count    = 0;
    skip_count    = 0;
    next_offset   = '0;
    section_hits  = '0;
  endtask

  task automatic scan_byte(input logic [7:0] data, input logic eos);
    logic [7:0]  w [5];
    int          cnt;
    int          n;
    logic [23:0] base;
    result_t     r;
    for (int i = 0; i < 5; i++) w[i] = '0;
    for (int i = 0; i < held_count; i++) w[i] = held_bytes[i];
    w[held_count] = data;
    cnt  = held_count + 1;
    base = next_offset - 24'(held_count);
    next_offset = next_offset + 24'd1;
    if (!eos) begin
      if (cnt == 3) begin
        if (judge_position(w[0], w[1], w[2], 3, base, r)) expect_result(r);
        held_bytes[0] = w[1];
        held_bytes[1] = w[2];
        held_count = 2;
      end else begin
        for (int i = 0; i < cnt; i++) held_bytes[i] = w[i];
        held_count = cnt;
      end
    end else begin
      // end of section: decide pending positions up to the first match, then the summary
      n = 0;
      for (int i = 0; i < cnt && n < 1; i++)
        if (judge_position(w[i], w[i+1], w[i+2], cnt - i, base + 24'(i), r)) begin
          expect_result(r);
          n++;
        end
      r = '0;
      r.kind  = KIND_SUMMARY;
      r.total = section_hits;
      r.last  = 1'b1;
      expect_result(r);
      clear_section();
    end
  endtask

  // Driver
  always @(negedge clk) begin : drive
    stream_byte_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (byte_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = byte_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nxt.data;
        in_tlast  <= nxt.eos;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor, checker and watchdog
  always @(posedge clk) begin : monitor
    result_t got;
    result_t exp;
    bit      busy;
    if (rst_n) begin
      busy = 1'b0;
      if (in_tvalid && in_tready) begin
        in_taken = 1'b1;
        busy = 1'b1;
        bytes_accepted++;
        scan_byte(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        busy = 1'b1;
        got.kind   = out_tuser;
        got.slot   = out_tdata[2:0];
        got.offset = out_tdata[26:3];
        got.total  = out_tdata[50:27];
        got.last   = out_tlast;
        if (predicted.size() == 0) begin
          errors++;
          $display("%0t: expected no result transaction", $time);
          $display("%0t:   actual kind=%0d slot=%0d offset=%0h total=%0d last=%0d",
                   $time, got.kind, got.slot, got.offset, got.total, got.last);
        end else begin
          exp = predicted.pop_front();
          if (got !== exp) begin
            errors++;
            $display("%0t: expected kind=%0d slot=%0d offset=%0h total=%0d last=%0d",
                     $time, exp.kind, exp.slot, exp.offset, exp.total, exp.last);
            $display("%0t:   actual kind=%0d slot=%0d offset=%0h total=%0d last=%0d",
                     $time, got.kind, got.slot, got.offset, got.total, got.last);
          end
          if (got.kind == KIND_SUMMARY) summaries_seen++;
          else reports_seen++;
        end
      end
      if (cfg_valid && cfg_ready) busy = 1'b1;
      stall_cycles = busy ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic write_slot(input logic [2:0] idx, input slot_reg_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < SLOT_COUNT) sig_slots[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Bytes are listed first-to-last from the high end of the vector.
  task automatic add_section(input logic [63:0] bytes, input int n);
    for (int k = 0; k < n; k++)
      queue_byte(bytes[8*(n-1-k) +: 8], (k == n - 1));
  endtask

  task automatic push_section(input int n);
    logic [7:0] sec [$];
    int         s;
    int         len;
    int         mode;
    while (sec.size() < n) begin
      mode = $urandom_range(0, 99);
      if (mode < 50) begin
        s = $urandom_range(0, SLOT_COUNT - 1);
        len = sig_slots[s][25:24];
        if (len < 2) len = 2;
        if (mode < 10) len = len - 1;   // broken: prefix only
        for (int k = 0; k < len; k++) sec.insert(sec.size(), sig_slots[s][23-8*k -: 8]);
      end else if (mode < 80) begin
        sec.insert(sec.size(), pick_alpha());
      end else begin
        sec.insert(sec.size(), 8'($urandom));
      end
    end
    while (sec.size() > n) void'(sec.pop_back());
    foreach (sec[i]) queue_byte(sec[i], (i == n - 1));
  endtask

  task automatic random_block(input int nbytes);
    int done;
    int seclen;
    done = 0;
    while (done < nbytes) begin
      seclen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      if (seclen > nbytes - done) seclen = nbytes - done;
      push_section(seclen);
      done += seclen;
    end
  endtask

  // Wait until every queued byte is sent and every predicted result is checked, then idle.
  task automatic wait_drained();
    while (byte_queue.size() > 0 || in_tvalid || predicted.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    for (int s = 0; s < SLOT_COUNT; s++) sig_slots[s] = SLOT_RESET[s];
    clear_section();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 76 : 0;
      recv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 31 : 0;
      if (ph == 0) begin
        // default signatures: exact hits, adjacent hits, truncation at section end
        add_section(64'h4890, 2);
        add_section(64'h8D40004889C0, 6);
        add_section(64'h66, 1);
        add_section(64'h00FF89, 3);
        add_section(64'h8BC0, 2);
        wait_drained();
        write_slot(3'd0, 26'h2AABB00);
        write_slot(3'd1, 26'h2BBAA00);
        write_slot(3'd2, 26'h1CC0000);   // length one counts as disabled
        write_slot(3'd3, 26'h0000000);
        write_slot(3'd4, 26'h3FFFFFF);
        write_slot(3'd5, 26'h2FFFF00);
        write_slot(3'd6, 26'h3FFFFFF);   // out-of-range index, ignored
        write_slot(3'd7, 26'h0000000);
        add_section(64'hAABBAABB, 4);    // covered position would hit slot 1
        add_section(64'hCCCC0000, 4);
        add_section(64'hFFFFFF, 3);
        add_section(64'hFFFF, 2);
      end
      for (int blk = 0; blk < 6; blk++) begin
        wait_drained();
        for (int s = 0; s < SLOT_COUNT; s++) begin
          if (blk == 1 && ph == 0) write_slot(3'(s), 26'h3FFFFFF);
          else if (blk == 1 && ph == 1) write_slot(3'(s), 26'h0000000);
          else if (blk == 1) write_slot(3'(s), SLOT_RESET[s]);
          else write_slot(3'(s), rand_slot());
        end
        if ($urandom_range(0, 1) == 1)
          write_slot(3'($urandom_range(SLOT_COUNT, 7)), slot_reg_t'($urandom));
        random_block(BLOCK_BYTES);
      end
    end
    wait_drained();

    $display("Scanned %0d bytes under 20 slot settings and three pacing modes;",
             bytes_accepted);
    $display("checked %0d match reports and %0d section summaries.",
             reports_seen, summaries_seen);
    if (errors == 0 && predicted.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
